@@ rtl/pwq_pkg.sv @@
// ----------------------------------------------------------------------------
// pwq_pkg
// Shared types and codes for the priority wait queue and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pwq_pkg;

    // Operation codes of an input transaction
    localparam logic OP_SUSPEND = 1'b0;
    localparam logic OP_RESUME  = 1'b1;

    // Ordering modes
    localparam logic MODE_FIFO     = 1'b0;
    localparam logic MODE_PRIORITY = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RESUMED  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // What a cell shows its neighbors
    typedef struct packed {
        logic       valid;
        logic       ins;     // new entry goes at or before this cell
        logic [7:0] handle;
        logic [7:0] prio;
    } t_link;

    // Broadcast control from the queue controller to every cell
    typedef struct packed {
        logic       insert;
        logic       drain;
        logic       mode;
        logic [7:0] new_handle;
        logic [7:0] new_prio;
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ rtl/pwq_cell.sv @@
// ----------------------------------------------------------------------------
// pwq_cell
// One slot of the wait queue: holds a handle and its priority, compares the
// incoming priority locally and shifts toward the tail on insert or toward
// the head on drain.
// ----------------------------------------------------------------------------
`default_nettype none

module pwq_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pwq_pkg::t_cell_ctrl i_ctrl,
    input  wire pwq_pkg::t_link    i_left,
    input  wire pwq_pkg::t_link    i_right,
    output pwq_pkg::t_link         o_link
);

    logic       r_valid;
    logic [7:0] r_handle;
    logic [7:0] r_prio;

    logic       w_hit;
    logic       w_ins;
    logic       w_take;
    logic [7:0] w_take_handle;
    logic [7:0] w_take_prio;

    // Local compare: this entry holds a larger priority value than the new one
    assign w_hit = r_valid && (i_ctrl.mode == pwq_pkg::MODE_PRIORITY)
                   && (i_ctrl.new_prio < r_prio);

    // The first hit from the head and every cell behind it shift toward the tail
    assign w_ins = w_hit || i_left.ins;

    // Load on insert when shifted over, or when this is the first empty slot
    assign w_take = (r_valid && w_ins) || (!r_valid && i_left.valid);
    assign w_take_handle = i_left.ins ? i_left.handle : i_ctrl.new_handle;
    assign w_take_prio   = i_left.ins ? i_left.prio   : i_ctrl.new_prio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.drain) begin
            r_valid  <= i_right.valid;
            r_handle <= i_right.handle;
            r_prio   <= i_right.prio;
        end else if (i_ctrl.insert && w_take) begin
            r_valid  <= 1'b1;
            r_handle <= w_take_handle;
            r_prio   <= w_take_prio;
        end
    end

    assign o_link.valid  = r_valid;
    assign o_link.ins    = w_ins;
    assign o_link.handle = r_handle;
    assign o_link.prio   = r_prio;

endmodule

`default_nettype wire

@@ rtl/priority_wait_queue.sv @@
// ----------------------------------------------------------------------------
// priority_wait_queue
// Bounded wait queue of thread handles, FIFO or priority ordered, built as a
// row of cells that compare locally and all shift in the same cycle.
// ----------------------------------------------------------------------------
// Suspend: its result is registered the cycle after acceptance.
// Resume all: acceptance enters the drain state, then one result per cycle
//   issues while the output register is free or read, as the row shifts to the head.
// The next transaction is taken once the previous results are issued and the
//   output register is free or being read.
// Reset (synchronous, active low) empties the queue and selects FIFO mode;
//   no clearing pass is needed.
`default_nettype none

module priority_wait_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata,
    // Input channel
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_operation,
    input  wire logic [7:0] i_thread_handle,
    input  wire logic [7:0] i_thread_priority,
    // Output channel
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_status,
    output logic [7:0]      o_resumed_handle,
    output logic            o_last_of_run
);

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } t_state;

    t_state     r_state;
    logic       r_ordering_mode;
    logic       r_o_valid;
    logic [1:0] r_o_status;
    logic [7:0] r_o_handle;
    logic       r_o_last;

    pwq_pkg::t_cell_ctrl            w_ctrl;
    pwq_pkg::t_link [QUEUE_DEPTH-1:0] w_link;
    pwq_pkg::t_link                 w_head_left;
    pwq_pkg::t_link                 w_tail_right;
    logic [QUEUE_DEPTH-1:0]         w_valid_vec;

    logic w_out_free;
    logic w_out_load;
    logic w_in_acc;
    logic w_full;
    logic w_empty;

    // Handshake
    assign w_out_free = !r_o_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_valid && o_ready;
    assign w_full     = w_link[QUEUE_DEPTH-1].valid;
    assign w_empty    = !w_link[0].valid;

    // Output register gets a new result this cycle
    assign w_out_load = (r_state == S_IDLE)
                        ? (w_in_acc && !((i_operation == pwq_pkg::OP_RESUME) && !w_empty))
                        : w_ctrl.drain;

    // Broadcast control to the cell row
    assign w_ctrl.insert     = w_in_acc && (i_operation == pwq_pkg::OP_SUSPEND) && !w_full;
    assign w_ctrl.drain      = (r_state == S_DRAIN) && w_out_free;
    assign w_ctrl.mode       = r_ordering_mode;
    assign w_ctrl.new_handle = i_thread_handle;
    assign w_ctrl.new_prio   = i_thread_priority;

    // Row boundaries: head sees an occupied non-shifting neighbor, tail sees empty
    assign w_head_left  = '{valid: 1'b1, ins: 1'b0, handle: 8'd0, prio: 8'd0};
    assign w_tail_right = '{valid: 1'b0, ins: 1'b0, handle: 8'd0, prio: 8'd0};

    // Cell row
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        pwq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_left  ((g == 0) ? w_head_left : w_link[(g == 0) ? 0 : g-1]),
            .i_right ((g == QUEUE_DEPTH-1) ? w_tail_right
                                           : w_link[(g == QUEUE_DEPTH-1) ? g : g+1]),
            .o_link  (w_link[g])
        );
        assign w_valid_vec[g] = w_link[g].valid;
    end

    // Controller state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_ordering_mode <= pwq_pkg::MODE_FIFO;
            r_o_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ordering_mode <= i_cfg_wdata;
            end
            if (r_o_valid && i_ready && !w_out_load) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_operation == pwq_pkg::OP_SUSPEND) begin
                            r_o_valid  <= 1'b1;
                            r_o_status <= w_full ? pwq_pkg::ST_FULL : pwq_pkg::ST_ENQUEUED;
                            r_o_handle <= 8'd0;
                            r_o_last   <= 1'b1;
                        end else if (w_empty) begin
                            r_o_valid  <= 1'b1;
                            r_o_status <= pwq_pkg::ST_EMPTY;
                            r_o_handle <= 8'd0;
                            r_o_last   <= 1'b1;
                        end else begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    // Issue head entry while the row shifts toward the head
                    if (w_out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= pwq_pkg::ST_RESUMED;
                        r_o_handle <= w_link[0].handle;
                        r_o_last   <= !w_link[1].valid;
                        if (!w_link[1].valid) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_resumed_handle = r_o_handle;
    assign o_last_of_run    = r_o_last;

`ifndef SYNTHESIS
    // Occupied cells always form a run starting at the head
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid_vec + 1'b1) & w_valid_vec) == '0)
        else $error("queue cells not contiguous");

    // Draining only happens with an entry at the head
    a_drain_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> w_link[0].valid)
        else $error("drain with empty head");

    // No new transaction is taken while a drain is running
    a_drain_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> !o_ready)
        else $error("input ready during drain");

    // A suspend gives exactly one final result in the next cycle
    a_suspend_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_operation == pwq_pkg::OP_SUSPEND)) |=> (o_valid && o_last_of_run))
        else $error("suspend result missing");
`endif

endmodule

`default_nettype wire
